/* design/mho_pkg.sv */
package mho_pkg;

    // Field widths of the pixel stream.
    localparam int INDEX_W   = 21;
    localparam int CHAN_W    = 8;
    localparam int HEAT_W    = 8;
    localparam int OPAC_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int NUM_W     = 16;

    typedef logic [2:0][CHAN_W-1:0] bgr_t;
    typedef logic [2:0][NUM_W-1:0]  bgr_num_t;
    typedef logic [2:0][CHAN_W:0]   bgr_diff_t;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY = 2'd2;

    localparam logic [HEAT_W-1:0] DECAY_RESET   = 8'd1;
    localparam logic [HEAT_W-1:0] GAIN_RESET    = 8'd10;
    localparam logic [OPAC_W-1:0] OPACITY_RESET = 9'd128;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

    // Colour ramp end points, index 0 is blue, 1 green, 2 red.
    localparam bgr_t COLD_BGR = {8'd100, 8'd200, 8'd255};
    localparam bgr_t HOT_BGR  = {8'd255, 8'd0, 8'd0};

    // Pipeline depth from an accepted request to the output register.
    localparam int PIPE_DEPTH = 5;

    // floor(n / 255) for n up to 255 * 255, by reciprocal with correction.
    function automatic logic [CHAN_W-1:0] div255(input logic [NUM_W-1:0] n);
        logic [NUM_W:0] t;
        t = {1'b0, n} + 17'd1 + {9'd0, n[15:8]};
        return t[15:8];
    endfunction

endpackage

/* design/motion_heatmap_overlay.sv */
// Motion heat map overlay.
//
// Input stream (s_*): one pixel per request, carrying its raster address, its
// BGR value and the moving / on-road flags. Output stream (m_*): one pixel per
// request, the blended BGR value and the pixel's updated heat.
// Configuration (cfg_*): decay, gain and Q8 opacity, written at any edge with
// cfg_we high; they should only change while the stream is idle.
//
// Throughput is one pixel per clock while m_tready is high and the clearing
// pass is over. The heat store is a single memory with one read and one write
// port; each pixel reads its heat when accepted and writes the updated value
// when it leaves stage 1, and a one-entry forward register covers a pixel
// that reads the address its predecessor is writing in the same cycle. The
// pipeline has five registers, stages 1 to 4 and the output register.
//
// After reset the heat store is cleared by a pass over all MAX_PIXELS entries,
// one entry per cycle; s_tready stays low until it finishes. Each pipeline stage
// holds its pixel while the next one is full, so a stalled receiver first
// lets the pipeline fill up (five pixels) before s_tready drops.
module motion_heatmap_overlay #(
    parameter int MAX_PIXELS = 2097152
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_index[20:0], pixel_blue[28:21], pixel_green[36:29], pixel_red[44:37], zero pad
    input  logic [mho_pkg::S_TDATA_W-1:0] s_tdata,
    // moving[0], on_road[1]
    input  logic [mho_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_blue[7:0], out_green[15:8], out_red[23:16], heat_level[31:24]
    output logic [mho_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [mho_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mho_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int IW    = mho_pkg::INDEX_W;
    localparam int HW    = mho_pkg::HEAT_W;
    localparam int CW    = mho_pkg::CHAN_W;

    // Configuration registers.
    logic [HW-1:0]              decay_reg;
    logic [HW-1:0]              gain_reg;
    logic [mho_pkg::OPAC_W-1:0] opacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= mho_pkg::DECAY_RESET;
            gain_reg    <= mho_pkg::GAIN_RESET;
            opacity_reg <= mho_pkg::OPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mho_pkg::CFG_DECAY:   decay_reg   <= cfg_data[HW-1:0];
                mho_pkg::CFG_GAIN:    gain_reg    <= cfg_data[HW-1:0];
                mho_pkg::CFG_OPACITY: opacity_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Input fields.
    logic [IW-1:0]  in_index;
    mho_pkg::bgr_t  in_bgr;
    logic           in_in_range;

    assign in_index    = s_tdata[20:0];
    assign in_bgr      = s_tdata[44:21];
    assign in_in_range = 32'(in_index) < 32'(MAX_PIXELS);

    // Stage valid bits and the load chain: a stage loads when it is empty or
    // its content moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic accept;
    logic clearing_reg;

    assign ld_out   = !m_valid_reg || m_tready;
    assign ld4      = !v4_reg || ld_out;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1 && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    // Clearing pass after reset.
    logic [IDX_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == IDX_W'(MAX_PIXELS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Stage 1 registers: the request, while the heat read is in flight.
    logic [IW-1:0] idx1_reg;
    logic          inr1_reg;
    logic          mov1_reg;
    logic          road1_reg;
    mho_pkg::bgr_t f1_reg;

    // Heat store.
    logic          ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic [HW-1:0] ram_rdata;
    logic          pipe_write;
    logic [HW-1:0] h1_next;

    assign pipe_write = v1_reg && ld2 && inr1_reg;
    assign ram_we     = clearing_reg || pipe_write;
    assign ram_waddr  = clearing_reg ? clr_addr_reg : IDX_W'(idx1_reg);
    assign ram_wdata  = clearing_reg ? '0 : h1_next;

    mho_heat_ram #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (IDX_W)
    ) u_heat_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ld1),
        .raddr (IDX_W'(in_index)),
        .rdata (ram_rdata)
    );

    // Forward register: the last heat written by the pipeline. It is always
    // the newest value for its address, so a hit can take it unconditionally.
    logic          fwd_valid_reg;
    logic [IW-1:0] fwd_idx_reg;
    logic [HW-1:0] fwd_heat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (pipe_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_write)
        begin
            fwd_idx_reg  <= idx1_reg;
            fwd_heat_reg <= h1_next;
        end
    end

    // Heat update: decay with a floor at zero, then gain with a ceiling
    // where motion lies on the road.
    logic [HW-1:0] h1_old;
    logic [HW-1:0] h1_dec;
    logic [HW:0]   h1_sum;

    always_comb
    begin
        if (!inr1_reg)
        begin
            h1_old = '0;
        end
        else if (fwd_valid_reg && (fwd_idx_reg == idx1_reg))
        begin
            h1_old = fwd_heat_reg;
        end
        else
        begin
            h1_old = ram_rdata;
        end
        h1_dec = (h1_old > decay_reg) ? (h1_old - decay_reg) : '0;
        h1_sum = {1'b0, h1_dec} + {1'b0, gain_reg};
        if (mov1_reg && road1_reg)
        begin
            h1_next = h1_sum[HW] ? mho_pkg::HEAT_MAX : h1_sum[HW-1:0];
        end
        else
        begin
            h1_next = h1_dec;
        end
    end

    // Stage 3 numerators of the colour ramp: (255 - h) * cold + h * hot.
    logic [HW-1:0]     h2_reg;
    logic              road2_reg;
    mho_pkg::bgr_t     f2_reg;
    mho_pkg::bgr_num_t n2_next;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            n2_next[ch] = ({8'd0, mho_pkg::HEAT_MAX - h2_reg} * {8'd0, mho_pkg::COLD_BGR[ch]})
                        + ({8'd0, h2_reg} * {8'd0, mho_pkg::HOT_BGR[ch]});
        end
    end

    // Stage 4: colour by division by 255, overlay selection, difference to
    // the frame pixel so the blend needs one multiplier per channel.
    logic [HW-1:0]      h3_reg;
    logic               road3_reg;
    mho_pkg::bgr_t      f3_reg;
    mho_pkg::bgr_num_t  n3_reg;
    mho_pkg::bgr_diff_t d3_next;

    always_comb
    begin
        logic [CW-1:0] v;
        for (int ch = 0; ch < 3; ch++)
        begin
            v = road3_reg ? mho_pkg::div255(n3_reg[ch]) : f3_reg[ch];
            d3_next[ch] = {1'b0, v} - {1'b0, f3_reg[ch]};
        end
    end

    // Output stage: f*256 + (v - f)*opacity, rounded half up, clamped to 0..255.
    logic [HW-1:0]      h4_reg;
    mho_pkg::bgr_t      f4_reg;
    mho_pkg::bgr_diff_t d4_reg;
    mho_pkg::bgr_t      o4_next;

    always_comb
    begin
        logic signed [19:0] dx;
        logic signed [19:0] opx;
        logic signed [19:0] sum;
        for (int ch = 0; ch < 3; ch++)
        begin
            dx  = 20'($signed(d4_reg[ch]));
            opx = $signed({11'd0, opacity_reg});
            sum = $signed({4'd0, f4_reg[ch], 8'd0}) + (dx * opx) + 20'sd128;
            if (sum[19])
            begin
                o4_next[ch] = '0;
            end
            else if (|sum[18:16])
            begin
                o4_next[ch] = 8'd255;
            end
            else
            begin
                o4_next[ch] = sum[15:8];
            end
        end
    end

    mho_pkg::bgr_t o_bgr_reg;
    logic [HW-1:0] o_heat_reg;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= accept;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                m_valid_reg <= v4_reg;
            end
        end
    end

    // Payload registers move with their stage.
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            idx1_reg  <= in_index;
            inr1_reg  <= in_in_range;
            mov1_reg  <= s_tuser[0];
            road1_reg <= s_tuser[1];
            f1_reg    <= in_bgr;
        end
        if (ld2)
        begin
            h2_reg    <= h1_next;
            road2_reg <= road1_reg;
            f2_reg    <= f1_reg;
        end
        if (ld3)
        begin
            h3_reg    <= h2_reg;
            road3_reg <= road2_reg;
            f3_reg    <= f2_reg;
            n3_reg    <= n2_next;
        end
        if (ld4)
        begin
            h4_reg <= h3_reg;
            f4_reg <= f3_reg;
            d4_reg <= d3_next;
        end
        if (ld_out)
        begin
            o_bgr_reg  <= o4_next;
            o_heat_reg <= h4_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_heat_reg, o_bgr_reg};

endmodule

/* design/mho_heat_ram.sv */
module mho_heat_ram #(
    parameter int DEPTH  = 2097152,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [mho_pkg::HEAT_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [mho_pkg::HEAT_W-1:0] rdata
);

    logic [mho_pkg::HEAT_W-1:0] mem [DEPTH];

    // Simple dual port, read data registered, old data on a same-address collision.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/mho_checker.sv */
module mho_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mho_pkg::M_TDATA_W-1:0] m_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign cnt_next = 3'(cnt_reg + 3'(in_acc) - 3'(out_acc));

    // Requests inside the block, accepted and not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // The heat store is cleared before the first pixel is taken.
    a_reset_blocks_input: assert property (@(posedge clk)
        !rst_n |=> !s_tready)
        else $error("input accepted right after reset, before the clearing pass");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output request changed or dropped");

    // Every output belongs to an accepted pixel and the pipeline holds at most five.
    a_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cnt_reg != 3'd0) && (cnt_reg <= 3'(mho_pkg::PIPE_DEPTH)))
        else $error("output request without a matching input, or pipeline overfull");

    // With the receiver ready throughout, a pixel appears after the full latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc, 5) && $past(m_tready, 1) && $past(m_tready, 2)
        && $past(m_tready, 3) && $past(m_tready, 4)
        && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)
        && $past(rst_n, 4) && $past(rst_n, 5) |-> m_tvalid)
        else $error("accepted pixel did not reach the output in time");

endmodule

bind motion_heatmap_overlay mho_checker u_mho_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
